FILE: src/mtts_pkg.sv
// Shared types, constants and helper functions for the Morton-tiled texture swizzle.
// Used by every module of the block; depends on nothing else.
package mtts_pkg;

    localparam int MAX_SIDE_LOG2 = 8;
    localparam int MIN_SIDE_LOG2 = 4;
    localparam int SIDE_W        = MAX_SIDE_LOG2;
    localparam int LOG2_W        = 4;
    localparam int TILE_LOG2     = 3;
    localparam int MORTON_W      = 2 * TILE_LOG2;
    localparam int IDX_W         = 2 * SIDE_W;
    localparam int TILE_W        = IDX_W - MORTON_W;
    localparam int PIXEL_W       = 16;
    localparam int INDEX_W       = 16;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_LOG2  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_LOG2 = CFG_INDEX_W'(1);

    typedef logic [SIDE_W-1:0]  coord_t;
    typedef logic [LOG2_W-1:0]  log2_t;
    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [INDEX_W-1:0] index_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } pos_t;

    function automatic log2_t side_log2(input log2_t l);
        log2_t result;
        if (l < LOG2_W'(MIN_SIDE_LOG2)) begin
            result = LOG2_W'(MIN_SIDE_LOG2);
        end else if (l > LOG2_W'(MAX_SIDE_LOG2)) begin
            result = LOG2_W'(MAX_SIDE_LOG2);
        end else begin
            result = l;
        end
        return result;
    endfunction

    function automatic coord_t side_mask(input log2_t l);
        logic [SIDE_W:0] one_hot;
        one_hot = (SIDE_W+1)'(1) << l;
        return SIDE_W'(one_hot - (SIDE_W+1)'(1));
    endfunction

endpackage

FILE: src/mtts_counter.sv
// Source column and row counters that walk the image in raster order.
// Produces the flipped destination coordinates and the end-of-image flag; uses mtts_pkg.
module mtts_counter (
    input  logic            aclk,
    input  logic            aresetn,
    input  mtts_pkg::log2_t width_log2,
    input  mtts_pkg::log2_t height_log2,
    input  logic            advance,
    output mtts_pkg::pos_t  pos
);
    import mtts_pkg::*;

    coord_t col_reg, col_next;
    coord_t row_reg, row_next;
    coord_t mask_w, mask_h;
    coord_t x, r;
    logic   x_end, r_end;

    always_comb begin
        mask_w   = side_mask(side_log2(width_log2));
        mask_h   = side_mask(side_log2(height_log2));
        x        = col_reg & mask_w;
        r        = row_reg & mask_h;
        x_end    = (x == mask_w);
        r_end    = (r == mask_h);
        pos.x    = x;
        pos.y    = mask_h - r;
        pos.last = x_end && r_end;
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (x_end) begin
                col_next = '0;
                row_next = (r + SIDE_W'(1)) & mask_h;
            end else begin
                col_next = x + SIDE_W'(1);
                row_next = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: src/mtts_swizzle.sv
// Tiled Morton index computation and red/blue channel exchange for one pixel.
// Purely combinational; uses mtts_pkg.
module mtts_swizzle (
    input  mtts_pkg::log2_t  width_log2,
    input  mtts_pkg::coord_t x,
    input  mtts_pkg::coord_t y,
    input  mtts_pkg::pixel_t pixel_in,
    output mtts_pkg::index_t tiled_index,
    output mtts_pkg::pixel_t pixel_out
);
    import mtts_pkg::*;

    log2_t                 row_shift;
    logic [TILE_W-1:0]     tile;
    logic [MORTON_W-1:0]   morton;
    logic [IDX_W-1:0]      idx;

    always_comb begin
        // Width is a power of two, so the tile column never carries into the tile row.
        row_shift   = side_log2(width_log2) - LOG2_W'(TILE_LOG2);
        tile        = (TILE_W'(y >> TILE_LOG2) << row_shift) | TILE_W'(x >> TILE_LOG2);
        morton      = {y[2], x[2], y[1], x[1], y[0], x[0]};
        idx         = {tile, morton};
        tiled_index = INDEX_W'(idx);
        pixel_out   = {pixel_in[4:0], pixel_in[10:5], pixel_in[15:11]};
    end

endmodule

FILE: src/morton_tile_texture_swizzle.sv
// Morton 8x8-tiled, vertically flipped texture swizzle for RGB565 pixel streams.
// Pixels pass the input register, then the result register; one pixel per cycle while
// m_ready is high. The input and result registers each hold one transaction, so input
// is taken while a result waits if the input register is empty. Synchronous active-low
// reset clears both stages, the position counters and sets both size exponents to 4 (16x16 image).
module morton_tile_texture_swizzle (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [mtts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  mtts_pkg::log2_t                      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  mtts_pkg::pixel_t                     s_pixel_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output mtts_pkg::index_t                     m_tiled_index,
    output mtts_pkg::pixel_t                     m_pixel_out,
    output logic                                 m_last_pixel
);
    import mtts_pkg::*;

    log2_t  width_log2_reg, height_log2_reg;
    pos_t   pos;
    logic   in_accept, s1_adv, out_adv;

    logic   s1_valid_reg;
    pixel_t s1_pixel_reg;
    pos_t   s1_pos_reg;

    index_t idx_calc;
    pixel_t pix_calc;

    logic   m_valid_reg;
    index_t m_index_reg;
    pixel_t m_pixel_reg;
    logic   m_last_reg;

    assign out_adv   = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_adv;
    assign s_ready   = !s1_valid_reg || out_adv;
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= LOG2_W'(MIN_SIDE_LOG2);
            height_log2_reg <= LOG2_W'(MIN_SIDE_LOG2);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH_LOG2:  width_log2_reg  <= cfg_wdata;
                REG_HEIGHT_LOG2: height_log2_reg <= cfg_wdata;
            endcase
        end
    end

    mtts_counter u_counter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .width_log2  (width_log2_reg),
        .height_log2 (height_log2_reg),
        .advance     (in_accept),
        .pos         (pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pixel_reg <= s_pixel_in;
            s1_pos_reg   <= pos;
        end
    end

    mtts_swizzle u_swizzle (
        .width_log2  (width_log2_reg),
        .x           (s1_pos_reg.x),
        .y           (s1_pos_reg.y),
        .pixel_in    (s1_pixel_reg),
        .tiled_index (idx_calc),
        .pixel_out   (pix_calc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_index_reg <= idx_calc;
            m_pixel_reg <= pix_calc;
            m_last_reg  <= s1_pos_reg.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tiled_index = m_index_reg;
    assign m_pixel_out   = m_pixel_reg;
    assign m_last_pixel  = m_last_reg;

endmodule

FILE: src/mtts_checker.sv
// Port-level checker for the texture swizzle, bound to the top level.
// Tracks transactions in flight; uses mtts_pkg.
module mtts_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input mtts_pkg::index_t                     m_tiled_index,
    input mtts_pkg::pixel_t                     m_pixel_out,
    input logic                                 m_last_pixel
);
    import mtts_pkg::*;

    logic [1:0] occ_reg, occ_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    always_comb begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer) begin
            occ_next = occ_reg + 2'd1;
        end else if (out_xfer && !in_xfer) begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 2'd0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid survived reset.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tiled_index)
            && $stable(m_pixel_out) && $stable(m_last_pixel))
        else $error("Stalled result changed.");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != 2'd0)
        else $error("Result shown with no transaction in flight.");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> occ_reg == 2'd2)
        else $error("Input stalled while the pipeline had room.");

endmodule

bind morton_tile_texture_swizzle mtts_checker u_mtts_checker (.*);
